### rtl/core/lhp_pkg.sv
// Shared package for the latency histogram block: widths, bucket geometry,
// record and query request types. No dependencies.
package lhp_pkg;

    localparam int unsigned STAMP_W        = 63;
    localparam int unsigned CNT_W          = 32;
    localparam int unsigned SUM_W          = 64;
    localparam int unsigned NUM_INTERVALS  = 8;
    localparam int unsigned NUM_STAMPS     = 8;
    localparam int unsigned IV_W           = 3;
    localparam int unsigned BASE_EXP_D     = 6;
    localparam int unsigned LINEAR_D       = 64;
    localparam int unsigned SUB_BITS_D     = 4;
    localparam int unsigned OCTAVES_D      = 20;
    localparam int unsigned QDEPTH         = 4;
    localparam int unsigned QPTR_W         = 2;

    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef logic [STAMP_W-1:0] t_stamp;

    typedef struct packed {
        logic                       func;
        logic [IV_W-1:0]            sel;
        logic [NUM_INTERVALS-1:0]   span_ok;
        t_stamp [NUM_INTERVALS-1:0] span;
    } t_req;

endpackage

### rtl/core/lhp_front.sv
// Front end of the latency histogram block: accepts commands, measures the
// eight interval spans of a record and forms a request. Depends on lhp_pkg.
module lhp_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_take,
    input  logic                   i_trace_enable,
    input  logic                   i_func,
    input  lhp_pkg::t_stamp [lhp_pkg::NUM_STAMPS-1:0] i_stamps,
    input  logic                   i_record_active,
    input  logic [lhp_pkg::IV_W-1:0] i_interval_sel,
    output logic                   o_valid,
    output lhp_pkg::t_req          o_req
);
    localparam logic [2:0] FROM [8] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0};
    localparam logic [2:0] TO   [8] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd7};

    logic          r_valid;
    lhp_pkg::t_req r_req;
    lhp_pkg::t_req n_req;
    logic          n_valid;

    always_comb begin
        lhp_pkg::t_stamp a;
        lhp_pkg::t_stamp b;
        n_req      = '0;
        n_req.func = i_func;
        n_req.sel  = i_interval_sel;
        for (int i = 0; i < lhp_pkg::NUM_INTERVALS; i++) begin
            a = i_stamps[FROM[i]];
            b = i_stamps[TO[i]];
            n_req.span[i]    = b - a;
            n_req.span_ok[i] = (a != '0) && (b != '0) && (b >= a);
        end
        n_valid = i_take && ((i_func == lhp_pkg::FUNC_QUERY) ||
                             (i_trace_enable && i_record_active));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_req <= n_req;
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;
endmodule

### rtl/core/lhp_queue.sv
// Small request queue between the front and back ends of the latency
// histogram block. Depends on lhp_pkg.
module lhp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lhp_pkg::t_req i_req,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [lhp_pkg::QPTR_W:0] o_count,
    output lhp_pkg::t_req o_req
);
    lhp_pkg::t_req r_mem [lhp_pkg::QDEPTH];
    logic [lhp_pkg::QPTR_W-1:0] r_wp;
    logic [lhp_pkg::QPTR_W-1:0] r_rp;
    logic [lhp_pkg::QPTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{lhp_pkg::QPTR_W{1'b0}}, i_push}
                           - {{lhp_pkg::QPTR_W{1'b0}}, i_pop};
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_req   = r_mem[r_rp];
endmodule

### rtl/core/lhp_back.sv
// Back end of the latency histogram block: bucket memory, sums, maxima,
// record count, clearing pass, percentile walk and mean divider. Uses lhp_pkg.
module lhp_back #(
    parameter int unsigned BASE_EXP       = lhp_pkg::BASE_EXP_D,
    parameter int unsigned LINEAR_BUCKETS = lhp_pkg::LINEAR_D,
    parameter int unsigned SUB_BITS       = lhp_pkg::SUB_BITS_D,
    parameter int unsigned OCTAVES        = lhp_pkg::OCTAVES_D
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  lhp_pkg::t_req i_req,
    output logic          o_pop,
    output logic          o_clearing,
    output logic          o_done,
    output logic [31:0]   o_sample_count,
    output lhp_pkg::t_stamp o_p50_ns,
    output lhp_pkg::t_stamp o_p90_ns,
    output lhp_pkg::t_stamp o_p99_ns,
    output lhp_pkg::t_stamp o_max_ns,
    output lhp_pkg::t_stamp o_mean_ns,
    output logic [31:0]   o_record_count
);
    localparam int unsigned SUB_COUNT = 1 << SUB_BITS;
    localparam int unsigned NB        = LINEAR_BUCKETS + OCTAVES * SUB_COUNT;
    localparam int unsigned BW        = $clog2(NB);
    localparam int unsigned DEPTH     = lhp_pkg::NUM_INTERVALS * (1 << BW);
    localparam int unsigned AW        = BW + lhp_pkg::IV_W;
    localparam int unsigned TW        = lhp_pkg::CNT_W + BW + 1;
    localparam int unsigned EW        = 6;
    localparam logic [BW-1:0] LAST_B  = BW'(NB - 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RREAD = 4'd2;
    localparam logic [3:0] S_RWAIT = 4'd3;
    localparam logic [3:0] S_RWR   = 4'd4;
    localparam logic [3:0] S_QSUM  = 4'd5;
    localparam logic [3:0] S_QPREP = 4'd6;
    localparam logic [3:0] S_QWALK = 4'd7;
    localparam logic [3:0] S_QDIV  = 4'd8;
    localparam logic [3:0] S_QOUT  = 4'd9;
    localparam logic [3:0] S_QMUL  = 4'd10;

    function automatic logic [BW-1:0] bucket_of(input lhp_pkg::t_stamp ns);
        int unsigned e;
        lhp_pkg::t_stamp s;
        e = 0;
        if (ns < 63'(LINEAR_BUCKETS)) begin
            return BW'(ns);
        end
        for (int k = 0; k < 63; k++) begin
            if (ns[k]) e = k;
        end
        if (e < BASE_EXP) e = BASE_EXP;
        if (e - BASE_EXP >= OCTAVES) return LAST_B;
        if (e >= SUB_BITS) s = ns >> (e - SUB_BITS);
        else               s = ns << (SUB_BITS - e);
        return BW'(LINEAR_BUCKETS + (e - BASE_EXP) * SUB_COUNT
                   + (s & 63'(SUB_COUNT - 1)));
    endfunction

    function automatic lhp_pkg::t_stamp floor_of(input logic [BW-1:0] b);
        int unsigned off;
        int unsigned e;
        int unsigned sub;
        logic [63:0] add;
        off = 0;
        if (b < BW'(LINEAR_BUCKETS)) begin
            return 63'(b);
        end
        off = 32'(b) - LINEAR_BUCKETS;
        e   = BASE_EXP + (off >> SUB_BITS);
        sub = off & (SUB_COUNT - 1);
        if (e > 62) return '1;
        if (e >= SUB_BITS) add = 64'(sub) << (e - SUB_BITS);
        else               add = 64'(sub) >> (SUB_BITS - e);
        return 63'((64'd1 << e) + add);
    endfunction

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;
    logic        r_we;
    logic [AW-1:0] r_waddr;
    logic [31:0] r_wdata;
    logic [AW-1:0] n_raddr;

    logic [3:0]  r_state;
    logic [AW-1:0] r_clr;
    logic [2:0]  r_iv;
    logic [BW-1:0] r_b;
    logic        r_rd_ok;
    lhp_pkg::t_req r_req;
    logic [63:0] r_sum [lhp_pkg::NUM_INTERVALS];
    logic [63:0] r_max [lhp_pkg::NUM_INTERVALS];
    logic [31:0] r_rec;
    logic [TW-1:0] r_total;
    logic [TW-1:0] r_seen;
    logic [TW+6:0] r_w50, r_w90, r_w99;
    logic        r_f50, r_f90, r_f99;
    lhp_pkg::t_stamp r_p50, r_p90, r_p99;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [EW:0] r_dcnt;
    logic        r_done;
    logic [1:0]  r_pipe;

    logic [TW-1:0] seen_nx;
    logic [TW+6:0] seen_x100;
    logic [64:0]   rem_sh;

    always_comb begin
        n_raddr = {r_iv, r_b};
        if (r_state == S_IDLE) n_raddr = {i_req.sel, {BW{1'b0}}};
        seen_nx   = r_seen + TW'(r_rdata);
        seen_x100 = ({7'd0, seen_nx} << 6) + ({7'd0, seen_nx} << 5)
                  + ({7'd0, seen_nx} << 2);
        rem_sh  = {r_rem, r_quo[63]};
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[n_raddr];
        if (r_we) r_mem[r_waddr] <= r_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_we    <= 1'b0;
            r_rec   <= '0;
            r_done  <= 1'b0;
            r_pipe  <= 2'd0;
            for (int i = 0; i < lhp_pkg::NUM_INTERVALS; i++) begin
                r_sum[i] <= '0;
                r_max[i] <= '0;
            end
        end else begin
            r_we   <= 1'b0;
            r_done <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_we    <= 1'b1;
                    r_waddr <= r_clr;
                    r_wdata <= '0;
                    r_clr   <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_req <= i_req;
                        r_iv  <= '0;
                        r_b   <= '0;
                        if (i_req.func == lhp_pkg::FUNC_QUERY) begin
                            r_iv    <= i_req.sel;
                            r_total <= '0;
                            r_state <= S_QSUM;
                        end else begin
                            if (r_rec != '1) r_rec <= r_rec + 1'b1;
                            r_state <= S_RREAD;
                        end
                    end
                end
                S_RREAD: begin
                    r_b     <= bucket_of(r_req.span[r_iv]);
                    r_rd_ok <= r_req.span_ok[r_iv];
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    r_state <= S_RWR;
                end
                S_RWR: begin
                    if (r_rd_ok) begin
                        r_we    <= 1'b1;
                        r_waddr <= {r_iv, r_b};
                        r_wdata <= (r_rdata == '1) ? r_rdata : r_rdata + 1'b1;
                        if (r_sum[r_iv] > ~{1'b0, r_req.span[r_iv]})
                            r_sum[r_iv] <= '1;
                        else
                            r_sum[r_iv] <= r_sum[r_iv] + {1'b0, r_req.span[r_iv]};
                        if ({1'b0, r_req.span[r_iv]} > r_max[r_iv])
                            r_max[r_iv] <= {1'b0, r_req.span[r_iv]};
                    end
                    r_iv <= r_iv + 1'b1;
                    if (r_iv == 3'd7) r_state <= S_IDLE;
                    else              r_state <= S_RREAD;
                end
                S_QSUM: begin
                    // rdata is registered from the address; r_pipe tracks priming
                    if (r_pipe != 2'd0) r_total <= r_total + TW'(r_rdata);
                    if (r_pipe == 2'd0) r_pipe <= 2'd1;
                    if (r_b == LAST_B) begin
                        r_pipe  <= 2'd2;
                        r_state <= (r_pipe == 2'd2) ? S_QMUL : S_QSUM;
                    end else begin
                        r_b <= r_b + 1'b1;
                    end
                end
                S_QMUL: begin
                    r_w50   <= (TW+7)'(r_total) * 7'd50;
                    r_w90   <= (TW+7)'(r_total) * 7'd90;
                    r_w99   <= (TW+7)'(r_total) * 7'd99;
                    r_state <= S_QPREP;
                end
                S_QPREP: begin
                    r_f50 <= 1'b0;
                    r_f90 <= 1'b0;
                    r_f99 <= 1'b0;
                    r_p50 <= '0;
                    r_p90 <= '0;
                    r_p99 <= '0;
                    r_seen <= '0;
                    r_b    <= '0;
                    r_pipe <= 2'd0;
                    r_rem  <= '0;
                    r_quo  <= r_sum[r_iv];
                    r_dcnt <= '0;
                    r_state <= (r_total == '0) ? S_QOUT : S_QWALK;
                end
                S_QWALK: begin
                    if (r_pipe == 2'd0) begin
                        r_pipe <= 2'd1;
                        r_b    <= r_b + 1'b1;
                    end else begin
                        r_seen <= seen_nx;
                        if (!r_f50 && seen_x100 >= r_w50) begin
                            r_f50 <= 1'b1;
                            r_p50 <= floor_of(r_b - 1'b1);
                        end
                        if (!r_f90 && seen_x100 >= r_w90) begin
                            r_f90 <= 1'b1;
                            r_p90 <= floor_of(r_b - 1'b1);
                        end
                        if (!r_f99 && seen_x100 >= r_w99) begin
                            r_f99 <= 1'b1;
                            r_p99 <= floor_of(r_b - 1'b1);
                        end
                        if (r_b - 1'b1 == LAST_B) begin
                            if (!r_f99 && seen_x100 < r_w99)
                                r_p99 <= floor_of(LAST_B);
                            r_state <= S_QDIV;
                        end else begin
                            r_b <= r_b + 1'b1;
                        end
                    end
                end
                S_QDIV: begin
                    if (rem_sh >= {1'b0, r_total > TW'(64'hFFFFFFFFFFFFFFFF) ?
                                   64'hFFFFFFFFFFFFFFFF : 64'(r_total)}) begin
                        r_rem <= 64'(rem_sh - 65'(r_total));
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[63:0];
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == (EW+1)'(63)) r_state <= S_QOUT;
                end
                S_QOUT: begin
                    r_done  <= 1'b1;
                    r_pipe  <= 2'd0;
                    r_b     <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_pop          = (r_state == S_IDLE) && !i_empty;
    assign o_clearing     = (r_state == S_CLEAR);
    assign o_done         = r_done;
    assign o_sample_count = (r_total > TW'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : r_total[31:0];
    assign o_p50_ns       = r_p50;
    assign o_p90_ns       = r_p90;
    assign o_p99_ns       = r_p99;
    assign o_max_ns       = r_max[r_iv][62:0];
    assign o_mean_ns      = (r_total == '0) ? '0 : r_quo[62:0];
    assign o_record_count = r_rec;
endmodule

### rtl/core/latency_histogram_percentiles.sv
// Latency histogram top level: front end, request queue, back end.
// Record: back end pops it, then walks 8 intervals through read, wait and write states.
// Query: sum, scale, percentile walk and mean divide; result strobe o_valid for one cycle.
// Reset: synchronous; a clearing pass over all 8*2^clog2(NUM_BUCKETS) entries
// (4096 by default) holds busy high. trace_enable resets to 1.
module latency_histogram_percentiles #(
    parameter int unsigned BASE_EXP       = lhp_pkg::BASE_EXP_D,
    parameter int unsigned LINEAR_BUCKETS = lhp_pkg::LINEAR_D,
    parameter int unsigned SUB_BITS       = lhp_pkg::SUB_BITS_D,
    parameter int unsigned OCTAVES        = lhp_pkg::OCTAVES_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_func,
    input  logic [62:0] i_stamp_post_entry,
    input  logic [62:0] i_stamp_post_handoff,
    input  logic [62:0] i_stamp_worker_start,
    input  logic [62:0] i_stamp_first_publish,
    input  logic [62:0] i_stamp_last_publish,
    input  logic [62:0] i_stamp_first_callback,
    input  logic [62:0] i_stamp_last_callback,
    input  logic [62:0] i_stamp_completion,
    input  logic        i_record_active,
    input  logic [2:0]  i_interval_sel,
    output logic        o_valid,
    output logic [31:0] o_sample_count,
    output logic [62:0] o_p50_ns,
    output logic [62:0] o_p90_ns,
    output logic [62:0] o_p99_ns,
    output logic [62:0] o_max_ns,
    output logic [62:0] o_mean_ns,
    output logic [31:0] o_record_count
);
    logic r_trace_enable;
    logic take;
    logic f_valid;
    lhp_pkg::t_req f_req;
    lhp_pkg::t_req q_req;
    logic q_empty;
    logic [lhp_pkg::QPTR_W:0] q_count;
    logic pop;
    logic clearing;
    lhp_pkg::t_stamp [lhp_pkg::NUM_STAMPS-1:0] stamps;

    assign stamps = {i_stamp_completion, i_stamp_last_callback, i_stamp_first_callback,
                     i_stamp_last_publish, i_stamp_first_publish, i_stamp_worker_start,
                     i_stamp_post_handoff, i_stamp_post_entry};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trace_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_trace_enable <= i_cfg_wdata;
        end
    end

    // hold off while clearing or when queue plus front stage could overflow
    assign busy = clearing ||
                  ((q_count + {{lhp_pkg::QPTR_W{1'b0}}, f_valid}) >=
                   (lhp_pkg::QPTR_W+1)'(lhp_pkg::QDEPTH - 1));
    assign take = start && !busy;

    lhp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_trace_enable  (r_trace_enable),
        .i_func          (i_func),
        .i_stamps        (stamps),
        .i_record_active (i_record_active),
        .i_interval_sel  (i_interval_sel),
        .o_valid         (f_valid),
        .o_req           (f_req)
    );

    lhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_req   (f_req),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_count (q_count),
        .o_req   (q_req)
    );

    lhp_back #(
        .BASE_EXP       (BASE_EXP),
        .LINEAR_BUCKETS (LINEAR_BUCKETS),
        .SUB_BITS       (SUB_BITS),
        .OCTAVES        (OCTAVES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_req          (q_req),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_done         (o_valid),
        .o_sample_count (o_sample_count),
        .o_p50_ns       (o_p50_ns),
        .o_p90_ns       (o_p90_ns),
        .o_p99_ns       (o_p99_ns),
        .o_max_ns       (o_max_ns),
        .o_mean_ns      (o_mean_ns),
        .o_record_count (o_record_count)
    );

`ifndef SYNTHESIS
    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !take) else $error("accept during clearing");
    a_no_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_valid) else $error("result during clearing");
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= (lhp_pkg::QPTR_W+1)'(lhp_pkg::QDEPTH)) else $error("queue overflow");
`endif
endmodule
